@@ hw/rtl/wait_channel_table_core_defines.svh @@
// Assertion macros shared by the wait channel table RTL.
// Self-contained; included by the top level that carries the assertions.
`ifndef WAIT_CHANNEL_TABLE_CORE_DEFINES_SVH
`define WAIT_CHANNEL_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WCT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WCT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/wct_pkg.sv @@
// Types and constants for the wait channel table.
// No dependencies; imported by every module of the block.
`default_nettype none
package wct_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_BLOCK    = 2'd0;
    localparam kind_t KIND_WAKE_ALL = 2'd1;
    localparam kind_t KIND_WAKE_ONE = 2'd2;
    localparam kind_t KIND_RESUME   = 2'd3;

    localparam int CHAN_W     = 32;
    localparam int TICK_W     = 32;
    localparam int RATE_W     = 17;
    localparam int TASK_W     = 4;
    localparam int MASK_W     = 16;
    localparam int S_TDATA_W  = 104;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 120;

    // Division by 1000 as a multiply by ceil(2^41 / 1000) and a right shift.
    // Exact for every 32-bit dividend.
    localparam logic [31:0] RECIP_1000  = 32'd2199023256;
    localparam int          RECIP_SHIFT = 41;
    localparam int          QUOT_W      = 64 - RECIP_SHIFT;

    localparam int RATE_RESET = 1000;

endpackage
`default_nettype wire

@@ hw/rtl/wct_slot_mem.sv @@
// Channel store of the wait channel table: one write port, one read port.
// Depends on wct_pkg for the channel width.
`default_nettype none
module wct_slot_mem import wct_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [CHAN_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [CHAN_W-1:0] rdata
);

    logic [CHAN_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/wct_deadline.sv @@
// Three-stage deadline unit: ms times tick rate, divide by 1000, add to now plus one; a zero wait gives zero.
// Depends on wct_pkg for widths and the reciprocal constant.
`default_nettype none
module wct_deadline import wct_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [TICK_W-1:0] wait_ms,
    input  wire logic [TICK_W-1:0] now_tick,
    input  wire logic [RATE_W-1:0] tick_rate,
    output logic                   done,
    output logic      [TICK_W-1:0] deadline
);

    logic              v1_reg, v2_reg, v3_reg;
    logic [TICK_W-1:0] prod_reg, prod_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [TICK_W-1:0] dl_reg, dl_next;
    logic [TICK_W+RATE_W-1:0] prod_full;
    logic [63:0]       recip_full;

    always_comb begin
        prod_full  = {{RATE_W{1'b0}}, wait_ms} * {{TICK_W{1'b0}}, tick_rate};
        prod_next  = prod_full[TICK_W-1:0];
        recip_full = {32'b0, prod_reg} * {32'b0, RECIP_1000};
        quot_next  = recip_full[63:RECIP_SHIFT];
        if (wait_ms == '0) begin
            dl_next = '0;
        end else begin
            dl_next = now_tick + {{(TICK_W-QUOT_W){1'b0}}, quot_reg} + TICK_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        dl_reg   <= dl_next;
    end

    assign done     = v3_reg;
    assign deadline = dl_reg;

endmodule
`default_nettype wire

@@ hw/rtl/wait_channel_table_core.sv @@
// Top level of the wait channel table: handshakes, sequencer, slot flags.
// Depends on wct_pkg, wct_slot_mem, wct_deadline and the assertion header.
`default_nettype none
`include "wait_channel_table_core_defines.svh"

// Wait channel table. Tasks block on a channel address, and wake beats
// release every blocked task on that channel (or only the lowest slot for
// wake one). Every input beat yields exactly one result beat. One item is
// worked on at a time: a block waits on the deadline multiply, divide-by-1000
// and add, a resume or a no-op beat goes straight to its result, and a wake
// scans every slot of the table in order, reading one slot per cycle
// through the single read port of the channel memory. A new beat is taken
// while the previous result still waits on the result port. The tick rate
// register may be written only while the block is idle.
module wait_channel_table_core import wct_pkg::*; #(
    parameter int TASK_SLOTS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // task_req[3:0], channel[35:4], wait_ms[67:36], now_tick[99:68], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // woken_mask[15:0], was_woken[16], deadline_tick[48:17],
    // wakeups_total[80:49], blocked_now[112:81], zero pad
    output logic      [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [RATE_W-1:0]    cfg_data
);

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = IW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [RATE_W-1:0]     rate_reg, rate_next;
    logic [TASK_SLOTS-1:0] blocked_reg, blocked_next;
    logic [TASK_SLOTS-1:0] chan_set_reg, chan_set_next;
    logic [31:0]           wake_cnt_reg, wake_cnt_next;
    logic [31:0]           blk_cnt_reg, blk_cnt_next;
    logic [CW-1:0]         rd_cnt_reg, rd_cnt_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic                  found_reg, found_next;
    logic                  m_valid_reg, m_valid_next;

    kind_t                 kind_reg, kind_next;
    logic [TASK_W-1:0]     task_reg, task_next;
    logic [CHAN_W-1:0]     chan_reg, chan_next;
    logic [TICK_W-1:0]     tmo_reg, tmo_next;
    logic [TICK_W-1:0]     now_reg, now_next;
    logic [IW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [MASK_W-1:0]     mask_reg, mask_next;
    logic [TICK_W-1:0]     dl_reg, dl_next;

    logic [MASK_W-1:0]     o_mask_reg, o_mask_next;
    logic                  o_woken_reg, o_woken_next;
    logic [TICK_W-1:0]     o_dl_reg, o_dl_next;
    logic [31:0]           o_wake_reg, o_wake_next;
    logic [31:0]           o_blk_reg, o_blk_next;

    logic                  s_accept;
    logic                  out_free;
    logic                  slot_ok;
    logic [IW-1:0]         task_idx;
    logic                  block_go;
    logic                  hit;
    logic                  mem_we;
    logic [CHAN_W-1:0]     mem_rdata;
    logic                  dl_start;
    logic                  dl_done;
    logic [TICK_W-1:0]     dl_value;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign slot_ok   = ({3'b0, task_reg} < 7'(TASK_SLOTS));
    assign task_idx  = IW'(task_reg);
    assign block_go  = (kind_reg == KIND_BLOCK) && slot_ok && (chan_reg != '0);
    assign hit       = cmp_valid_reg && blocked_reg[cmp_idx_reg] && (mem_rdata == chan_reg)
                       && !((kind_reg == KIND_WAKE_ONE) && found_reg);
    assign dl_start  = s_accept && (s_tuser == KIND_BLOCK);
    assign mem_we    = (state_reg == S_DONE) && out_free && block_go;

    wct_slot_mem #(
        .DEPTH (TASK_SLOTS),
        .AW    (IW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (task_idx),
        .wdata (chan_reg),
        .raddr (rd_cnt_reg[IW-1:0]),
        .rdata (mem_rdata)
    );

    // The deadline is worked out for every block beat; the result is only
    // used when the block actually takes effect.
    wct_deadline u_deadline (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (dl_start),
        .wait_ms    (tmo_next),
        .now_tick   (now_next),
        .tick_rate  (rate_reg),
        .done       (dl_done),
        .deadline   (dl_value)
    );

    always_comb begin
        state_next     = state_reg;
        rate_next      = rate_reg;
        blocked_next   = blocked_reg;
        chan_set_next  = chan_set_reg;
        wake_cnt_next  = wake_cnt_reg;
        blk_cnt_next   = blk_cnt_reg;
        rd_cnt_next    = rd_cnt_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        kind_next      = kind_reg;
        task_next      = task_reg;
        chan_next      = chan_reg;
        tmo_next       = tmo_reg;
        now_next       = now_reg;
        mask_next      = mask_reg;
        dl_next        = dl_reg;
        o_mask_next    = o_mask_reg;
        o_woken_next   = o_woken_reg;
        o_dl_next      = o_dl_reg;
        o_wake_next    = o_wake_reg;
        o_blk_next     = o_blk_reg;

        if (cfg_valid) begin
            rate_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    kind_next   = s_tuser;
                    task_next   = s_tdata[3:0];
                    chan_next   = s_tdata[35:4];
                    tmo_next    = s_tdata[67:36];
                    now_next    = s_tdata[99:68];
                    mask_next   = '0;
                    found_next  = 1'b0;
                    rd_cnt_next = '0;
                    if (s_tuser == KIND_BLOCK) begin
                        state_next = S_CALC;
                    end else if ((s_tuser == KIND_WAKE_ALL || s_tuser == KIND_WAKE_ONE)
                                 && s_tdata[35:4] != '0) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CALC: begin
                if (dl_done) begin
                    dl_next    = dl_value;
                    state_next = S_DONE;
                end
            end
            S_SCAN: begin
                // The compare sees the read data in the cycle after its address is set; the memory is
                // not written during a scan, so no forwarding is needed.
                if (rd_cnt_reg < CW'(TASK_SLOTS)) begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_cnt_reg[IW-1:0];
                    rd_cnt_next    = rd_cnt_reg + CW'(1);
                end
                if (hit) begin
                    blocked_next[cmp_idx_reg]  = 1'b0;
                    chan_set_next[cmp_idx_reg] = 1'b0;
                    wake_cnt_next = wake_cnt_reg + 32'd1;
                    if (blk_cnt_reg != '0) begin
                        blk_cnt_next = blk_cnt_reg - 32'd1;
                    end
                    mask_next  = mask_reg | (MASK_W'(1) << cmp_idx_reg);
                    found_next = 1'b1;
                end
                if (!cmp_valid_reg && rd_cnt_reg == CW'(TASK_SLOTS)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_woken_next = 1'b0;
                    o_dl_next    = '0;
                    if (block_go) begin
                        blocked_next[task_idx]  = 1'b1;
                        chan_set_next[task_idx] = 1'b1;
                        blk_cnt_next = blk_cnt_reg + 32'd1;
                        o_dl_next    = dl_reg;
                    end
                    if (kind_reg == KIND_RESUME && slot_ok) begin
                        o_woken_next            = !chan_set_reg[task_idx];
                        blocked_next[task_idx]  = 1'b0;
                        chan_set_next[task_idx] = 1'b0;
                    end
                    o_mask_next  = mask_reg;
                    o_wake_next  = wake_cnt_next;
                    o_blk_next   = blk_cnt_next;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rate_reg      <= RATE_W'(RATE_RESET);
            blocked_reg   <= '0;
            chan_set_reg  <= '0;
            wake_cnt_reg  <= '0;
            blk_cnt_reg   <= '0;
            rd_cnt_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rate_reg      <= rate_next;
            blocked_reg   <= blocked_next;
            chan_set_reg  <= chan_set_next;
            wake_cnt_reg  <= wake_cnt_next;
            blk_cnt_reg   <= blk_cnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        task_reg    <= task_next;
        chan_reg    <= chan_next;
        tmo_reg     <= tmo_next;
        now_reg     <= now_next;
        cmp_idx_reg <= cmp_idx_next;
        mask_reg    <= mask_next;
        dl_reg      <= dl_next;
        o_mask_reg  <= o_mask_next;
        o_woken_reg <= o_woken_next;
        o_dl_reg    <= o_dl_next;
        o_wake_reg  <= o_wake_next;
        o_blk_reg   <= o_blk_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, o_blk_reg, o_wake_reg, o_dl_reg, o_woken_reg, o_mask_reg};

    `WCT_ASSERT_IMP(a_cmp_only_in_scan, aclk, aresetn, cmp_valid_reg, state_reg == S_SCAN, "compare valid outside a scan")
    `WCT_ASSERT_IMP(a_wake_one_single, aclk, aresetn, state_reg == S_SCAN && kind_reg == KIND_WAKE_ONE, $countones(mask_reg) <= 1, "wake one woke more than one slot")
    `WCT_ASSERT_IMP(a_dl_done_in_calc, aclk, aresetn, dl_done, state_reg == S_CALC, "deadline result arrived outside the wait for it")
    `WCT_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_accept, !s_tready, "input taken again before the item finished")

endmodule
`default_nettype wire

@@ dv/wait_channel_table_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for wait_channel_table_core: block, wake and resume beats
// are checked against an in-bench model of the slot table. Needs only wct_pkg and the RTL.
module wait_channel_table_core_test;
    import wct_pkg::*;

    localparam int          SLOT_COUNT   = 16;
    localparam logic [31:0] MS_PER_SEC   = 32'd1000;
    localparam int          PHASE_OPS    = 330;
    localparam int          HOLD_AT      = 900;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          DRAIN_CYCLES = 30;

    typedef struct packed {
        kind_t              kind;
        logic [TASK_W-1:0]  slot;
        logic [CHAN_W-1:0]  chan;
        logic [31:0]        timeout;
        logic [TICK_W-1:0]  now;
    } table_op_t;

    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic               woken;
        logic [TICK_W-1:0]  deadline;
        logic [31:0]        wakeups;
        logic [31:0]        blocked;
    } table_outcome_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [RATE_W-1:0]    cfg_data  = '0;

    wait_channel_table_core #(
        .TASK_SLOTS(SLOT_COUNT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Model of the slot table.
    logic              slot_blocked [SLOT_COUNT];
    logic [CHAN_W-1:0] slot_chan    [SLOT_COUNT];
    logic [31:0]       wake_count   = '0;
    logic [31:0]       block_count  = '0;
    logic [RATE_W-1:0] tick_rate    = RATE_W'(RATE_RESET);

    table_op_t      op_backlog [$];
    table_outcome_t outcome_fifo [$];
    table_op_t      op_on_bus;
    table_outcome_t want, got;

    int  items_queued  = 0;
    int  results_seen  = 0;
    int  errors        = 0;
    int  hold_left     = 0;
    int  quiet_cycles  = 0;
    int  n_block       = 0;
    int  n_wake        = 0;
    int  n_resume      = 0;
    bit  no_idle       = 1'b0;
    bit  hold_done     = 1'b0;
    logic [CHAN_W-1:0] chan_pool [4];

    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_blocked[i] = 1'b0;
            slot_chan[i]    = '0;
        end
    end

    function automatic table_outcome_t apply_table_op(input table_op_t op);
        table_outcome_t res;
        logic [31:0]    scaled;
        bit             stop;
        res  = '0;
        stop = 1'b0;
        case (op.kind)
            KIND_BLOCK: begin
                if (op.chan != '0) begin
                    if (op.timeout != '0) begin
                        // The product wraps at 32 bits before the divide.
                        scaled       = op.timeout * {15'd0, tick_rate};
                        res.deadline = op.now + scaled / MS_PER_SEC + 32'd1;
                    end
                    slot_chan[op.slot]    = op.chan;
                    slot_blocked[op.slot] = 1'b1;
                    block_count           = block_count + 32'd1;
                end
            end
            KIND_WAKE_ALL, KIND_WAKE_ONE: begin
                if (op.chan != '0) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (!stop && slot_blocked[i] && slot_chan[i] == op.chan) begin
                            slot_chan[i]    = '0;
                            slot_blocked[i] = 1'b0;
                            wake_count      = wake_count + 32'd1;
                            if (block_count != '0) block_count = block_count - 32'd1;
                            if (i < MASK_W) res.mask[i] = 1'b1;
                            stop = (op.kind == KIND_WAKE_ONE);
                        end
                    end
                end
            end
            default: begin
                // Resume reports whether a wake already cleared the channel.
                res.woken             = (slot_chan[op.slot] == '0);
                slot_chan[op.slot]    = '0;
                slot_blocked[op.slot] = 1'b0;
            end
        endcase
        res.wakeups = wake_count;
        res.blocked = block_count;
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
            errors++;
        end
    endtask

    // Driver: one beat on the input channel at a time, predicted when it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                outcome_fifo.push_back(apply_table_op(op_on_bus));
                case (op_on_bus.kind)
                    KIND_BLOCK:  n_block++;
                    KIND_RESUME: n_resume++;
                    default:     n_wake++;
                endcase
            end
            if (!s_tvalid || s_tready) begin
                if (op_backlog.size() != 0 && (no_idle || $urandom_range(99) >= 12)) begin
                    op_on_bus = op_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'd0, op_on_bus.now, op_on_bus.timeout, op_on_bus.chan,
                                 op_on_bus.slot};
                    s_tuser  <= op_on_bus.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.mask     = m_tdata[15:0];
            got.woken    = m_tdata[16];
            got.deadline = m_tdata[48:17];
            got.wakeups  = m_tdata[80:49];
            got.blocked  = m_tdata[112:81];
            if (outcome_fifo.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, expected none, got %h",
                         $time, m_tdata);
                errors++;
            end else begin
                want = outcome_fifo.pop_front();
                results_seen++;
                check_field("woken_mask", 32'(want.mask), 32'(got.mask));
                check_field("was_woken", 32'(want.woken), 32'(got.woken));
                check_field("deadline_tick", want.deadline, got.deadline);
                check_field("wakeups_total", want.wakeups, got.wakeups);
                check_field("blocked_now", want.blocked, got.blocked);
                if (results_seen == HOLD_AT && !hold_done) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= no_idle || $urandom_range(99) >= 12;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t ns: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("[wait_channel_table_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_op(input kind_t kind, input logic [TASK_W-1:0] slot,
                          input logic [31:0] chan, input logic [31:0] timeout,
                          input logic [31:0] now);
        table_op_t op;
        op.kind    = kind;
        op.slot    = slot;
        op.chan    = chan;
        op.timeout = timeout;
        op.now     = now;
        op_backlog.push_back(op);
        items_queued++;
    endtask

    task automatic add_random_op();
        int          pick;
        logic [31:0] chan;
        logic [31:0] timeout;
        kind_t       kind;
        pick = $urandom_range(99);
        if (pick < 40)      kind = KIND_BLOCK;
        else if (pick < 60) kind = KIND_WAKE_ALL;
        else if (pick < 80) kind = KIND_WAKE_ONE;
        else                kind = KIND_RESUME;
        // Mostly a few shared channels so that wakes find sleepers.
        pick = $urandom_range(99);
        if (pick < 6)       chan = '0;
        else if (pick < 12) chan = $urandom();
        else                chan = chan_pool[$urandom_range(3)];
        pick = $urandom_range(3);
        if (pick == 0)      timeout = '0;
        else if (pick == 1) timeout = $urandom_range(1000, 1);
        else                timeout = $urandom();
        add_op(kind, TASK_W'($urandom_range(SLOT_COUNT - 1)), chan, timeout, $urandom());
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued) @(posedge aclk);
    endtask

    task automatic set_tick_rate(input logic [RATE_W-1:0] rate);
        cfg_data  <= rate;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tick_rate = rate;
    endtask

    initial begin
        logic [RATE_W-1:0] rates [6];
        rates[0] = 17'd1;
        rates[1] = 17'd100000;
        rates[2] = 17'h1FFFF;
        rates[3] = 17'd0;
        rates[4] = RATE_W'($urandom_range(100000, 1));
        rates[5] = 17'd1000;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, at the reset tick rate.
        add_op(KIND_BLOCK,    4'd0,  32'd1,          32'd0,          32'd0);
        add_op(KIND_BLOCK,    4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        add_op(KIND_BLOCK,    4'd1,  32'd0,          32'd50,         32'd10);
        add_op(KIND_BLOCK,    4'd2,  32'h1234,       32'd5,          32'd100);
        add_op(KIND_BLOCK,    4'd3,  32'h1234,       32'd1,          32'hFFFF_FFF0);
        add_op(KIND_BLOCK,    4'd2,  32'h1234,       32'd9999,       32'd7);
        add_op(KIND_WAKE_ONE, 4'd9,  32'h1234,       32'd0,          32'd0);
        add_op(KIND_WAKE_ALL, 4'd15, 32'h1234,       32'hFFFF_FFFF,  32'hFFFF_FFFF);
        add_op(KIND_WAKE_ALL, 4'd0,  32'd0,          32'd0,          32'd0);
        add_op(KIND_WAKE_ALL, 4'd0,  32'hFFFF_FFFF,  32'd0,          32'd0);
        add_op(KIND_RESUME,   4'd2,  32'd0,          32'd0,          32'd0);
        add_op(KIND_RESUME,   4'd0,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        add_op(KIND_WAKE_ALL, 4'd0,  32'd1,          32'd0,          32'd0);
        add_op(KIND_WAKE_ONE, 4'd0,  32'hDEAD_BEEF,  32'd0,          32'd0);
        add_op(KIND_RESUME,   4'd9,  32'd0,          32'd0,          32'd0);
        for (int i = 4; i < 8; i++) add_op(KIND_BLOCK, TASK_W'(i), 32'd5, 32'd3, 32'd1000);
        add_op(KIND_WAKE_ONE, 4'd0,  32'd5,          32'd0,          32'd0);
        add_op(KIND_WAKE_ALL, 4'd0,  32'd5,          32'd0,          32'd0);
        add_op(KIND_RESUME,   4'd5,  32'd0,          32'd0,          32'd0);
        wait_drained();

        // Random part, one tick rate per phase; the second phase runs without idling.
        for (int p = 0; p < 6; p++) begin
            set_tick_rate(rates[p]);
            for (int i = 0; i < 4; i++) begin
                chan_pool[i] = $urandom();
                if (chan_pool[i] == '0) chan_pool[i] = 32'd1;
            end
            no_idle = (p == 1);
            for (int i = 0; i < PHASE_OPS; i++) add_random_op();
            wait_drained();
        end
        no_idle = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (outcome_fifo.size() != 0) begin
            $display("%0t ns: results missing, expected %0d more, got 0", $time,
                     outcome_fifo.size());
            errors++;
        end
        $display("Run covered %0d beats over 7 tick rates: %0d block, %0d wake, %0d resume;",
                 results_seen, n_block, n_wake, n_resume);
        $display("%0d tasks woken, one long result stall, %0d mismatches.", wake_count, errors);
        if (errors == 0) begin
            $display("[wait_channel_table_core] OK");
        end else begin
            $display("[wait_channel_table_core] ERROR");
        end
        $finish;
    end

endmodule
